// File: design/tangent_cross_seed_generator_assert.svh
// assertion macros for the tangent cross seed generator
// used by modules that check their own control logic; needs clk and rst in scope
`ifndef TANGENT_CROSS_SEED_GENERATOR_ASSERT_SVH
`define TANGENT_CROSS_SEED_GENERATOR_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define TCSG_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TCSG_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition holds in the cycle after reset
`define TCSG_CHECK_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: design/tcsg_pkg.sv
// shared types and constants of the tangent cross seed generator
// no dependencies; imported by every module of the block
package tcsg_pkg;

  // pipeline depths
  localparam int NORM_STEPS  = 5;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int LEN_LAT     = NORM_STEPS + SQRT_STAGES;
  localparam int NUM_OFF     = 5;

  // offset component slots
  localparam int OFF_T1X = 0;
  localparam int OFF_T1Y = 1;
  localparam int OFF_T2X = 2;
  localparam int OFF_T2Y = 3;
  localparam int OFF_T2Z = 4;

  // seed order within one point
  localparam logic [1:0] SEED_T1_PLUS  = 2'd0;
  localparam logic [1:0] SEED_T1_MINUS = 2'd1;
  localparam logic [1:0] SEED_T2_PLUS  = 2'd2;
  localparam logic [1:0] SEED_T2_MINUS = 2'd3;

  localparam logic [30:0] DIST_RESET = 31'd65536;

  typedef logic [4:0] kshift_t;

  // everything a point needs up to the dividers
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               axis;
    logic [NUM_OFF-1:0] neg;
    logic [15:0]        mag_nx;
    logic [15:0]        mag_ny;
    logic [30:0]        mag_xz;
    logic [30:0]        mag_yz;
    logic [31:0]        r2;
  } front_side_t;

  // what a point keeps after the dividers
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               axis;
    logic [NUM_OFF-1:0] neg;
  } back_side_t;

  // finished point handed to the serializer
  typedef struct packed {
    logic signed [31:0]            px;
    logic signed [31:0]            py;
    logic signed [31:0]            pz;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic [NUM_OFF-1:0]            neg;
    logic [NUM_OFF-1:0][30:0]      off;
  } seed_src_t;

endpackage

// File: design/tangent_cross_seed_generator.sv
// a point passes the 74-stage datapath, the serializer's point holder and its output register
// throughput: one seed word per cycle while m_tready is high; the serializer's four output
//   words per point limit the point rate; the datapath takes a word per cycle when not stalled
// reset: clears all valid bits and the serializer and sets offset_distance to 1.0;
//   no clearing pass, the block accepts words in the first cycle after reset
module tangent_cross_seed_generator import tcsg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [167:0]  s_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                  // red_in, green_in, blue_in
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data,  // offset_distance
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,  // seed_x, seed_y, seed_z, red_out, green_out, blue_out
  output logic [1:0]    m_tuser,  // seed_index
  output logic          m_tlast
);

  logic [30:0] offset_distance;
  logic        adv;
  logic        ser_ready;

  // input fields
  logic [15:0] nx;
  logic [15:0] ny;
  logic [15:0] nz;
  logic [15:0] mnx;
  logic [15:0] mny;
  logic [15:0] mnz;

  // stage a
  front_side_t a_side;
  logic [30:0] a_nx2;
  logic [30:0] a_ny2;
  logic [30:0] a_nz2;
  logic        a_v;
  // stage b
  front_side_t b_side;
  front_side_t b_next;
  logic [32:0] b_t3;
  logic        b_v;
  // stage c
  front_side_t c_side;
  logic [63:0] c_s2;
  logic        c_v;
  logic [64:0] s2_full;
  // length units
  front_side_t       len_side [LEN_LAT];
  logic [LEN_LAT-1:0] len_v;
  logic [31:0] len1;
  logic [31:0] len2;
  kshift_t     k1;
  kshift_t     k2;
  // stage d
  back_side_t  d_side;
  logic [31:0] d_a [NUM_OFF];
  logic [31:0] d_len1;
  logic [31:0] d_len2;
  logic        d_v;
  // dividers
  back_side_t           div_side [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_v;
  logic [30:0] unit [NUM_OFF];
  // stage e
  back_side_t  e_side;
  logic [61:0] e_prod [NUM_OFF];
  logic        e_v;
  // stage f
  seed_src_t   f_src;
  logic        f_v;
  logic [30:0] f_mag [NUM_OFF];

  function automatic logic [31:0] shl_k(input logic [31:0] m, input kshift_t k);
    logic [63:0] w;
    w = {32'd0, m} << k;
    return w[31:0];
  endfunction

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_distance <= DIST_RESET;
    end else if (cfg_valid) begin
      offset_distance <= cfg_data;
    end
  end

  // whole pipeline moves together
  assign adv      = !f_v || ser_ready;
  assign s_tready = adv;

  assign nx  = s_tdata[111:96];
  assign ny  = s_tdata[127:112];
  assign nz  = s_tdata[143:128];
  assign mnx = nx[15] ? 16'(~nx + 16'd1) : nx;
  assign mny = ny[15] ? 16'(~ny + 16'd1) : ny;
  assign mnz = nz[15] ? 16'(~nz + 16'd1) : nz;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      len_v <= '0;
      d_v   <= 1'b0;
      div_v <= '0;
      e_v   <= 1'b0;
      f_v   <= 1'b0;
    end else if (adv) begin
      a_v   <= s_tvalid;
      b_v   <= a_v;
      c_v   <= b_v;
      len_v <= {len_v[LEN_LAT-2:0], c_v};
      d_v   <= len_v[LEN_LAT-1];
      div_v <= {div_v[DIV_STAGES-2:0], d_v};
      e_v   <= div_v[DIV_STAGES-1];
      f_v   <= e_v;
    end
  end

  // stage a: magnitudes, squares and cross products
  always_ff @(posedge clk) begin
    if (adv) begin
      a_side.px     <= s_tdata[31:0];
      a_side.py     <= s_tdata[63:32];
      a_side.pz     <= s_tdata[95:64];
      a_side.red    <= s_tdata[151:144];
      a_side.green  <= s_tdata[159:152];
      a_side.blue   <= s_tdata[167:160];
      a_side.axis   <= (nx == '0) && (ny == '0);
      a_side.neg[OFF_T1X] <= ny[15];
      a_side.neg[OFF_T1Y] <= !nx[15];
      a_side.neg[OFF_T2X] <= !(nx[15] ^ nz[15]);
      a_side.neg[OFF_T2Y] <= !(ny[15] ^ nz[15]);
      a_side.neg[OFF_T2Z] <= 1'b0;
      a_side.mag_nx <= mnx;
      a_side.mag_ny <= mny;
      a_side.mag_xz <= 31'(32'(mnx) * 32'(mnz));
      a_side.mag_yz <= 31'(32'(mny) * 32'(mnz));
      a_side.r2     <= '0;
      a_nx2 <= 31'(32'(mnx) * 32'(mnx));
      a_ny2 <= 31'(32'(mny) * 32'(mny));
      a_nz2 <= 31'(32'(mnz) * 32'(mnz));
    end
  end

  // stage b: squared lengths
  always_comb begin
    b_next    = a_side;
    b_next.r2 = 32'(a_nx2) + 32'(a_ny2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side <= b_next;
      b_t3   <= 33'(a_nx2) + 33'(a_ny2) + 33'(a_nz2);
    end
  end

  // stage c: squared length of the second tangent
  assign s2_full = {33'd0, b_side.r2} * {32'd0, b_t3};
  always_ff @(posedge clk) begin
    if (adv) begin
      c_side <= b_side;
      c_s2   <= s2_full[63:0];
    end
  end

  // tangent lengths
  tcsg_len u_len1 (
    .clk     (clk),
    .en      (adv),
    .sq_in   ({32'd0, c_side.r2}),
    .len_out (len1),
    .k_out   (k1)
  );

  tcsg_len u_len2 (
    .clk     (clk),
    .en      (adv),
    .sq_in   (c_s2),
    .len_out (len2),
    .k_out   (k2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      len_side[0] <= c_side;
      for (int i = 1; i < LEN_LAT; i++) begin
        len_side[i] <= len_side[i-1];
      end
    end
  end

  // stage d: scale numerators by the normalizing shift
  always_ff @(posedge clk) begin
    if (adv) begin
      d_side.px    <= len_side[LEN_LAT-1].px;
      d_side.py    <= len_side[LEN_LAT-1].py;
      d_side.pz    <= len_side[LEN_LAT-1].pz;
      d_side.red   <= len_side[LEN_LAT-1].red;
      d_side.green <= len_side[LEN_LAT-1].green;
      d_side.blue  <= len_side[LEN_LAT-1].blue;
      d_side.axis  <= len_side[LEN_LAT-1].axis;
      d_side.neg   <= len_side[LEN_LAT-1].neg;
      d_a[OFF_T1X] <= shl_k({16'd0, len_side[LEN_LAT-1].mag_ny}, k1);
      d_a[OFF_T1Y] <= shl_k({16'd0, len_side[LEN_LAT-1].mag_nx}, k1);
      d_a[OFF_T2X] <= shl_k({1'b0, len_side[LEN_LAT-1].mag_xz}, k2);
      d_a[OFF_T2Y] <= shl_k({1'b0, len_side[LEN_LAT-1].mag_yz}, k2);
      d_a[OFF_T2Z] <= shl_k(len_side[LEN_LAT-1].r2, k2);
      d_len1 <= len1;
      d_len2 <= len2;
    end
  end

  // unit components
  for (genvar g = 0; g < NUM_OFF; g++) begin : g_div
    tcsg_div u_div (
      .clk (clk),
      .en  (adv),
      .a   (d_a[g]),
      .dvs ((g < OFF_T2X) ? d_len1 : d_len2),
      .q   (unit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_side[0] <= d_side;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_side[i] <= div_side[i-1];
      end
    end
  end

  // stage e: scale by offset distance
  always_ff @(posedge clk) begin
    if (adv) begin
      e_side <= div_side[DIV_STAGES-1];
      for (int i = 0; i < NUM_OFF; i++) begin
        e_prod[i] <= {31'd0, offset_distance} * {31'd0, unit[i]};
      end
    end
  end

  // stage f: round half up, axis case
  always_comb begin
    for (int i = 0; i < NUM_OFF; i++) begin
      f_mag[i] = 31'((e_prod[i] + 62'(64'd1 << 29)) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_src.px    <= e_side.px;
      f_src.py    <= e_side.py;
      f_src.pz    <= e_side.pz;
      f_src.red   <= e_side.red;
      f_src.green <= e_side.green;
      f_src.blue  <= e_side.blue;
      f_src.neg   <= e_side.axis ? '0 : e_side.neg;
      for (int i = 0; i < NUM_OFF; i++) begin
        if (!e_side.axis) begin
          f_src.off[i] <= f_mag[i];
        end else if (i == OFF_T1X || i == OFF_T2Y) begin
          f_src.off[i] <= offset_distance;
        end else begin
          f_src.off[i] <= '0;
        end
      end
    end
  end

  // four seeds per point
  tcsg_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_v),
    .in_src   (f_src),
    .in_ready (ser_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/tcsg_len.sv
// pipelined length unit: even-shift normalization then integer square root
// depends on tcsg_pkg; NORM_STEPS normalize stages then SQRT_STAGES root stages, one value per cycle while en is high
module tcsg_len import tcsg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] sq_in,
  output logic [31:0] len_out,
  output kshift_t     k_out
);

  logic [63:0] nx_r [NORM_STEPS];
  kshift_t     nk_r [NORM_STEPS];
  logic [63:0] sx_r [SQRT_STAGES];
  logic [63:0] sr_r [SQRT_STAGES];
  kshift_t     sk_r [SQRT_STAGES];

  // normalize: shift by pairs of bits until the top pair is reached
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int STEP = 16 >> j;
    localparam int HB = 2 + 2 * STEP;
    logic [63:0] xi;
    kshift_t     ki;
    if (j == 0) begin : g_first
      assign xi = sq_in;
      assign ki = '0;
    end else begin : g_rest
      assign xi = nx_r[j-1];
      assign ki = nk_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (xi[63 -: HB] == '0) begin
          nx_r[j] <= xi << (2 * STEP);
          nk_r[j] <= ki + kshift_t'(STEP);
        end else begin
          nx_r[j] <= xi;
          nk_r[j] <= ki;
        end
      end
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * i);
    logic [63:0] xi;
    logic [63:0] ri;
    kshift_t     ki;
    logic [63:0] trial;
    if (i == 0) begin : g_first
      assign xi = nx_r[NORM_STEPS-1];
      assign ri = '0;
      assign ki = nk_r[NORM_STEPS-1];
    end else begin : g_rest
      assign xi = sx_r[i-1];
      assign ri = sr_r[i-1];
      assign ki = sk_r[i-1];
    end
    assign trial = ri + RBIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          sx_r[i] <= xi - trial;
          sr_r[i] <= (ri >> 1) + RBIT;
        end else begin
          sx_r[i] <= xi;
          sr_r[i] <= ri >> 1;
        end
        sk_r[i] <= ki;
      end
    end
  end

  assign len_out = sr_r[SQRT_STAGES-1][31:0];
  assign k_out   = sk_r[SQRT_STAGES-1];

endmodule

// File: design/tcsg_div.sv
// pipelined restoring divider: q = floor(a * 2^30 / dvs) for a <= dvs
// depends on tcsg_pkg; DIV_STAGES stages, one quotient bit per stage
module tcsg_div import tcsg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] dvs,
  output logic [30:0] q
);

  logic [32:0] rem_r [DIV_STAGES];
  logic [30:0] quo_r [DIV_STAGES];
  logic [31:0] dv_r  [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [32:0] ri;
    logic [30:0] qi;
    logic [31:0] di;
    if (i == 0) begin : g_first
      assign ri = {1'b0, a};
      assign qi = '0;
      assign di = dvs;
    end else begin : g_rest
      assign ri = {rem_r[i-1][31:0], 1'b0};
      assign qi = quo_r[i-1];
      assign di = dv_r[i-1];
    end
    // compare and subtract, one bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (ri >= {1'b0, di}) begin
          rem_r[i] <= ri - {1'b0, di};
          quo_r[i] <= {qi[29:0], 1'b1};
        end else begin
          rem_r[i] <= ri;
          quo_r[i] <= {qi[29:0], 1'b0};
        end
        dv_r[i] <= di;
      end
    end
  end

  assign q = quo_r[DIV_STAGES-1];

endmodule

// File: design/tcsg_ser.sv
// seed serializer: holds one point and sends its four seeds through an output register
// depends on tcsg_pkg and tangent_cross_seed_generator_assert.svh
`include "tangent_cross_seed_generator_assert.svh"
module tcsg_ser import tcsg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  seed_src_t     in_src,
  output logic          in_ready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,  // seed_x, seed_y, seed_z, red_out, green_out, blue_out
  output logic [1:0]    m_tuser,  // seed_index
  output logic          m_tlast
);

  seed_src_t    hold;
  logic         hv;
  logic [1:0]   cnt;
  logic         o_valid;
  logic [119:0] o_data;
  logic [1:0]   o_idx;
  logic         o_last;

  logic         load_out;
  logic         emit;
  logic         take;
  logic         sel_t2;
  logic         minus;
  logic [31:0]  sx;
  logic [31:0]  sy;
  logic [31:0]  sz;

  function automatic logic [31:0] sat_step(input logic signed [31:0] p,
                                           input logic [30:0] mag,
                                           input logic neg);
    logic signed [33:0] m;
    logic signed [33:0] s;
    m = $signed({3'b000, mag});
    s = $signed({{2{p[31]}}, p}) + (neg ? -m : m);
    if (s > $signed(34'sh0_7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (s < $signed(-34'sh0_8000_0000)) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // handshake on both sides
  assign load_out = !o_valid || m_tready;
  assign emit     = hv && load_out;
  assign in_ready = !hv || (emit && cnt == SEED_T2_MINUS);
  assign take     = in_valid && in_ready;

  // seed of the current count
  assign sel_t2 = cnt[1];
  assign minus  = cnt[0];
  assign sx = sat_step(hold.px, sel_t2 ? hold.off[OFF_T2X] : hold.off[OFF_T1X],
                       (sel_t2 ? hold.neg[OFF_T2X] : hold.neg[OFF_T1X]) ^ minus);
  assign sy = sat_step(hold.py, sel_t2 ? hold.off[OFF_T2Y] : hold.off[OFF_T1Y],
                       (sel_t2 ? hold.neg[OFF_T2Y] : hold.neg[OFF_T1Y]) ^ minus);
  assign sz = sat_step(hold.pz, sel_t2 ? hold.off[OFF_T2Z] : '0,
                       (sel_t2 && hold.neg[OFF_T2Z]) ^ minus);

  // point holder and seed counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hv  <= 1'b0;
      cnt <= SEED_T1_PLUS;
    end else if (take) begin
      hv  <= 1'b1;
      cnt <= SEED_T1_PLUS;
    end else if (emit) begin
      cnt <= cnt + 2'd1;
      if (cnt == SEED_T2_MINUS) begin
        hv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= in_src;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_data <= {hold.blue, hold.green, hold.red, sz, sy, sx};
      o_idx  <= cnt;
      o_last <= (cnt == SEED_T2_MINUS);
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tuser  = o_idx;
  assign m_tlast  = o_last;

  // checks
  `TCSG_CHECK_NOW(tcsg_last_flag, m_tvalid, m_tlast == (m_tuser == SEED_T2_MINUS), "last flag not on fourth seed")
  `TCSG_CHECK_NEXT(tcsg_hold_midway, emit && cnt != SEED_T2_MINUS, hv, "point dropped before its fourth seed")
  `TCSG_CHECK_NEXT(tcsg_emit_order, emit, m_tvalid && m_tuser == $past(cnt), "seed word out of order")
  `TCSG_CHECK_RESET(tcsg_reset_empty, !m_tvalid && !hv, "serializer not empty after reset")

endmodule
